/* design/sent_frame_receiver_top_macros.svh */
// Assertion macros shared by the SENT frame receiver modules.
// Expects clk and rst_n in the scope of each use.
`ifndef SENT_FRAME_RECEIVER_TOP_MACROS_SVH
`define SENT_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication
`define SFR_ASSERT_IMPL(name, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("sfr assertion failed");

// Next-cycle implication
`define SFR_ASSERT_NEXT(name, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("sfr assertion failed");

`endif

/* design/sfr_pkg.sv */
// Package for the SENT frame receiver: types, codes, constants, CRC table.
// Used by sfr_dpath, sfr_ctrl and the top level; depends on nothing.
package sfr_pkg;

  localparam int unsigned ADDR_W = 3;

  localparam logic [7:0]  SYNC_LOW      = 8'd126;
  localparam logic [7:0]  SYNC_HIGH     = 8'd210;
  localparam logic [7:0]  SYNC_NOMINAL  = 8'd168;
  localparam logic [7:0]  NIBBLE_OFFSET = 8'd35;
  localparam logic [7:0]  NIBBLE_MAX    = 8'd47;
  localparam logic [3:0]  CRC_SEED      = 4'd5;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5;
  localparam logic [2:0]  LAST_DATA_NIB = 3'd7;

  localparam logic [0:0] REG_TIMEOUT = 1'b0;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] RES_GOOD    = 2'd0;
  localparam logic [1:0] RES_CRC_ERR = 2'd1;
  localparam logic [1:0] RES_TIMEOUT = 2'd2;

  localparam logic [3:0] CRC_TABLE [16] = '{
    4'd0, 4'd13, 4'd7, 4'd10, 4'd14, 4'd3, 4'd9, 4'd4,
    4'd1, 4'd12, 4'd6, 4'd11, 4'd15, 4'd2, 4'd8, 4'd5
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic direct;
    logic div_done;
    logic has_result;
    logic out_busy;
  } sts_t;

  // floor(v/3) for v below 48: multiply by 43, drop 7 bits
  function automatic logic [3:0] div3(input logic [5:0] v);
    logic [11:0] prod;
    prod = {6'd0, v} * 12'd43;
    return prod[10:7];
  endfunction

endpackage

/* design/sfr_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by sfr_dpath.
module sfr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output logic [15:0] quotient,
  output logic        done
);

  logic        busy_r, busy_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [8:0]  shifted;
  logic [8:0]  diff;
  logic        ge;

  always_comb begin
    shifted  = {rem_r, quo_r[15]};
    ge       = shifted >= {1'b0, divisor};
    diff     = shifted - {1'b0, divisor};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[7:0] : shifted[7:0];
      quo_nxt = {quo_r[14:0], ge};
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

/* design/sfr_dpath.sv */
// Datapath of the SENT frame receiver: frame state, nibble decode, CRC, output register.
// Depends on sfr_pkg and sfr_div.
module sfr_dpath (
  input  logic          clk,
  input  logic          rst_n,
  input  sfr_pkg::cmd_t cmd,
  output sfr_pkg::sts_t sts,
  input  logic          in_op,
  input  logic [7:0]    in_edge,
  input  logic [15:0]   timeout_ms,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_code,
  output logic [3:0]    out_status,
  output logic [11:0]   out_data_one,
  output logic [11:0]   out_data_two
);

  logic        op_r;
  logic [7:0]  edge_r;
  logic [7:0]  last_r, last_nxt;
  logic [7:0]  sync_r, sync_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [3:0]  crc_r, crc_nxt;
  logic [15:0] ms_r, ms_nxt;
  logic [3:0]  store_r [7];
  logic        store_we;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_code_r, code_nxt;
  logic [3:0]  out_st_r;
  logic [11:0] out_d1_r, out_d2_r;

  logic [7:0]  d;
  logic        is_sync;
  logic [15:0] dividend;
  logic [15:0] quotient;
  logic        div_done;
  logic [7:0]  v;
  logic [3:0]  nib;
  logic [15:0] ms_inc;
  logic        has_result;

  always_comb begin
    d        = edge_r - last_r;
    is_sync  = (d > sfr_pkg::SYNC_LOW) && (d < sfr_pkg::SYNC_HIGH);
    dividend = ({8'd0, d} * {8'd0, sfr_pkg::SYNC_NOMINAL}) + {9'd0, sync_r[7:1]};
    v        = quotient[7:0] - sfr_pkg::NIBBLE_OFFSET;
    nib      = sfr_pkg::div3(v[5:0]);
    ms_inc   = (ms_r == 16'hFFFF) ? ms_r : ms_r + 16'd1;
  end

  sfr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (sync_r),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    last_nxt   = last_r;
    sync_nxt   = sync_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    ms_nxt     = ms_r;
    store_we   = 1'b0;
    has_result = 1'b0;
    code_nxt   = sfr_pkg::RES_GOOD;
    if (op_r == sfr_pkg::OP_TICK) begin
      ms_nxt = ms_inc;
      if (ms_inc >= timeout_ms) begin
        ms_nxt     = '0;
        sync_nxt   = '0;
        cnt_nxt    = '0;
        has_result = 1'b1;
        code_nxt   = sfr_pkg::RES_TIMEOUT;
      end
    end else begin
      last_nxt = edge_r;
      if (is_sync) begin
        sync_nxt = d;
        cnt_nxt  = '0;
        crc_nxt  = sfr_pkg::CRC_SEED;
      end else if (sync_r != 8'd0) begin
        if (v > sfr_pkg::NIBBLE_MAX) begin
          sync_nxt = '0;
          cnt_nxt  = '0;
        end else if (cnt_r != sfr_pkg::LAST_DATA_NIB) begin
          store_we = 1'b1;
          crc_nxt  = sfr_pkg::CRC_TABLE[crc_r ^ nib];
          cnt_nxt  = cnt_r + 3'd1;
        end else begin
          sync_nxt   = '0;
          cnt_nxt    = '0;
          ms_nxt     = '0;
          has_result = 1'b1;
          code_nxt   = (nib == crc_r) ? sfr_pkg::RES_GOOD : sfr_pkg::RES_CRC_ERR;
        end
      end
    end
  end

  always_comb begin
    sts.direct     = (op_r == sfr_pkg::OP_TICK) || is_sync || (sync_r == 8'd0);
    sts.div_done   = div_done;
    sts.has_result = has_result;
    sts.out_busy   = out_valid_r && !out_ready;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (cmd.commit && has_result) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      sync_r      <= '0;
      cnt_r       <= '0;
      crc_r       <= sfr_pkg::CRC_SEED;
      ms_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.commit) begin
        last_r <= last_nxt;
        sync_r <= sync_nxt;
        cnt_r  <= cnt_nxt;
        crc_r  <= crc_nxt;
        ms_r   <= ms_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      edge_r <= in_edge;
    end
    if (cmd.commit && store_we) begin
      for (int i = 0; i < 7; i++) begin
        if (cnt_r == 3'(i)) begin
          store_r[i] <= nib;
        end
      end
    end
    if (cmd.commit && has_result) begin
      out_code_r <= code_nxt;
      if (code_nxt == sfr_pkg::RES_GOOD) begin
        out_st_r <= store_r[0];
        out_d1_r <= {store_r[1], store_r[2], store_r[3]};
        out_d2_r <= {store_r[4], store_r[5], store_r[6]};
      end else begin
        out_st_r <= '0;
        out_d1_r <= '0;
        out_d2_r <= '0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_code     = out_code_r;
  assign out_status   = out_st_r;
  assign out_data_one = out_d1_r;
  assign out_data_two = out_d2_r;

endmodule

/* design/sfr_ctrl.sv */
// Controller of the SENT frame receiver: sequences capture, divide and commit.
// Depends on sfr_pkg and the assertion macro header.
`include "sent_frame_receiver_top_macros.svh"

module sfr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sfr_pkg::sts_t sts,
  output sfr_pkg::cmd_t cmd
);

  sfr_pkg::state_t state_r, state_nxt;
  logic            st_idle;
  logic            st_eval;
  logic            st_div;
  logic            st_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.div_start = 1'b0;
    cmd.commit    = 1'b0;
    case (state_r)
      sfr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sfr_pkg::ST_EVAL;
        end
      end
      sfr_pkg::ST_EVAL: begin
        if (sts.direct) begin
          state_nxt = sfr_pkg::ST_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = sfr_pkg::ST_DIV;
        end
      end
      sfr_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = sfr_pkg::ST_FIN;
        end
      end
      sfr_pkg::ST_FIN: begin
        // hold while the item has a result and the result register is still full
        if (!(sts.has_result && sts.out_busy)) begin
          cmd.commit = 1'b1;
          state_nxt  = sfr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sfr_pkg::ST_IDLE;
      end
    endcase
  end

  assign st_idle = (state_r == sfr_pkg::ST_IDLE);
  assign st_eval = (state_r == sfr_pkg::ST_EVAL);
  assign st_div  = (state_r == sfr_pkg::ST_DIV);
  assign st_fin  = (state_r == sfr_pkg::ST_FIN);

  `SFR_ASSERT_NEXT(a_accept_to_eval, st_idle && in_valid, st_eval)
  `SFR_ASSERT_NEXT(a_hold_on_full, st_fin && sts.has_result && sts.out_busy, st_fin)
  `SFR_ASSERT_NEXT(a_div_to_fin, st_div && sts.div_done, st_fin)
  `SFR_ASSERT_IMPL(a_done_in_div, sts.div_done, st_div)

endmodule

/* design/sent_frame_receiver_top.sv */
// SENT frame receiver top level: one item at a time; a tick or a sync or pre-sync edge
// goes through eval and fin back to ready, a nibble edge also through div, where the
// serial divider runs. A result is registered into the output register at commit and
// may wait there while the next item is accepted. rst_n is synchronous, active low:
// it clears the frame state, sets the CRC seed to 5 and timeout_ms to 5.
module sent_frame_receiver_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] edge_time
  input  logic                       in_tuser,   // [0] operation
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // [3:0] status_nibble, [15:4] data_one,
                                                 // [27:16] data_two, [31:28] zero
  output logic [1:0]                 out_tuser,  // [1:0] result_code
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  sfr_pkg::cmd_t cmd;
  sfr_pkg::sts_t sts;
  logic [15:0]   timeout_r;
  logic          cfg_wr;
  logic [3:0]    st;
  logic [11:0]   d1;
  logic [11:0]   d2;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == sfr_pkg::REG_TIMEOUT);
  assign cfg_prdata = (cfg_paddr[2] == sfr_pkg::REG_TIMEOUT) ? {16'd0, timeout_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= sfr_pkg::TIMEOUT_RESET;
    end else if (cfg_wr) begin
      timeout_r <= cfg_pwdata[15:0];
    end
  end

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfr_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (in_tuser),
    .in_edge      (in_tdata),
    .timeout_ms   (timeout_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_code     (out_tuser),
    .out_status   (st),
    .out_data_one (d1),
    .out_data_two (d2)
  );

  assign out_tdata = {4'd0, d2, d1, st};

endmodule
